@@ design/hcfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcfr_pkg
// shared types and constants of the header/checksum frame receiver
// ----------------------------------------------------------------------------
package hcfr_pkg;

	// store depth default
	localparam int BUFFER_DEPTH_DEF = 64;

	// register file
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 8'd1;

	localparam int LEN_W = 7;
	localparam logic [7:0] HEADER_RESET = 8'd85;
	localparam logic [LEN_W-1:0] LENGTH_RESET = 7'd28;
	localparam logic [LEN_W-1:0] LENGTH_MIN = 7'd2;

	// result beat layout in m_tdata, lowest bit up
	localparam int POS_W = 6;
	localparam int CNT_W = 32;
	localparam int DATA_LSB = 0;
	localparam int POS_LSB = 8;
	localparam int GOOD_LSB = POS_LSB + POS_W;
	localparam int BAD_LSB = GOOD_LSB + CNT_W;
	localparam int SEEN_LSB = BAD_LSB + CNT_W;
	localparam int PAYLOAD_W = SEEN_LSB + CNT_W;
	localparam int TDATA_W = ((PAYLOAD_W + 7) / 8) * 8;

	// result kinds carried in tuser
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_CKS_ERR = 1'b1;

	typedef enum logic {
		ST_RUN,
		ST_REPLAY
	} state_t;

endpackage
`default_nettype wire

@@ design/header_checksum_frame_receiver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// header_checksum_frame_receiver
// fixed-length frame sync on a header byte, additive 8-bit checksum check,
// replay of the stored payload of good frames
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------
//  s_      | in  | one received link byte
//  m_      | out | payload byte of a good frame, or one checksum error result
//  cfg_    | in  | register write: index 0 header byte, index 1 frame length
//
//  hunted, header and payload bytes give no result
//  a good frame replays its stored payload by the synchronous store read and
//  then the output register load, with a single read in flight on the one
//  store read port
//  s_tready is low during replay and while a result beat waits on m_tready
//  arst_n clears control state and counters; store contents are not cleared
//
module header_checksum_frame_receiver
	import hcfr_pkg::*;
#(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	// received byte stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte

	// result stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [7:0] data_byte, [13:8] byte_position, [45:14] good_frames,
	// [77:46] bad_frames, [109:78] bytes_seen, [111:110] zero
	output logic [TDATA_W-1:0]         m_tdata,
	output logic [0:0]                 m_tuser,   // [0] kind
	output logic                       m_tlast,   // last

	// configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam logic [LEN_W-1:0] LENGTH_MAX = LEN_W'(BUFFER_DEPTH);

	// configuration registers
	logic [7:0]       header_q;
	logic [LEN_W-1:0] length_q;

	// frame capture state
	logic              in_frame_q;
	logic [ADDR_W-1:0] fill_q;
	logic [7:0]        sum_q;

	// counters
	logic [CNT_W-1:0] seen_q;
	logic [CNT_W-1:0] good_q;
	logic [CNT_W-1:0] bad_q;

	// replay sequencer
	state_t            state_q;
	state_t            state_d;
	logic [ADDR_W-1:0] replay_n_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic              rd_issue;

	// store read stage
	logic              rd_pend_s1;
	logic [7:0]        rd_data_s1;
	logic [ADDR_W-1:0] rd_pos_s1;
	logic              rd_last_s1;

	// output register
	logic              out_kind_q;
	logic [7:0]        out_data_q;
	logic [POS_W-1:0]  out_pos_q;
	logic              out_last_q;

	// frame store
	logic [7:0] store_mem [BUFFER_DEPTH];

	logic [LEN_W-1:0] eff_len;
	logic             in_acc;
	logic             is_cks;
	logic             cks_ok;
	logic             out_free;

	// frame length saturated to the range the store supports
	always_comb begin
		priority if (length_q < LENGTH_MIN) begin
			eff_len = LENGTH_MIN;
		end else if (length_q > LENGTH_MAX) begin
			eff_len = LENGTH_MAX;
		end else begin
			eff_len = length_q;
		end
	end

	assign out_free  = !m_tvalid || m_tready;
	assign s_tready  = (state_q == ST_RUN) && out_free;
	assign in_acc    = s_tvalid && s_tready;
	// a byte is the checksum once the payload fills length minus one
	assign is_cks    = !((LEN_W'(fill_q) + LEN_W'(1)) < eff_len);
	assign cks_ok    = (sum_q == s_tdata);
	assign cfg_ready = 1'b1;

	// sequencer next state and read issue
	always_comb begin
		state_d  = state_q;
		rd_issue = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				if (in_acc && in_frame_q && is_cks && cks_ok) begin
					state_d = ST_REPLAY;
				end
			end
			ST_REPLAY: begin
				// one read in flight; its beat lands in a free output register
				rd_issue = (rd_ptr_q != replay_n_q) && !rd_pend_s1 && out_free;
				if (rd_pend_s1 && rd_last_s1) begin
					state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			length_q <= LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HEADER_BYTE:  header_q <= cfg_data;
				REG_FRAME_LENGTH: length_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// hunt, capture and checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			fill_q     <= '0;
			sum_q      <= '0;
			seen_q     <= '0;
			good_q     <= '0;
			bad_q      <= '0;
			replay_n_q <= '0;
		end else if (in_acc) begin
			seen_q <= seen_q + CNT_W'(1);
			if (!in_frame_q) begin
				if (s_tdata == header_q) begin
					in_frame_q <= 1'b1;
					fill_q     <= '0;
					sum_q      <= '0;
				end
			end else if (!is_cks) begin
				fill_q <= fill_q + ADDR_W'(1);
				sum_q  <= sum_q + s_tdata;
			end else begin
				in_frame_q <= 1'b0;
				fill_q     <= '0;
				sum_q      <= '0;
				if (cks_ok) begin
					good_q     <= good_q + CNT_W'(1);
					replay_n_q <= fill_q;
				end else begin
					bad_q <= bad_q + CNT_W'(1);
				end
			end
		end
	end

	// store write port
	always_ff @(posedge clk) begin
		if (in_acc && in_frame_q && !is_cks) begin
			store_mem[fill_q] <= s_tdata;
		end
	end

	// store read port, registered data
	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_data_s1 <= store_mem[rd_ptr_q];
			rd_pos_s1  <= rd_ptr_q;
			rd_last_s1 <= (rd_ptr_q + ADDR_W'(1)) == replay_n_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
			rd_ptr_q   <= '0;
		end else begin
			rd_pend_s1 <= rd_issue;
			if (state_q == ST_RUN) begin
				rd_ptr_q <= '0;
			end else if (rd_issue) begin
				rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
			end
		end
	end

	// output register: error result or replayed payload beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (in_acc && in_frame_q && is_cks && !cks_ok) begin
			m_tvalid <= 1'b1;
		end else if (rd_pend_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_frame_q && is_cks && !cks_ok) begin
			out_kind_q <= KIND_CKS_ERR;
			out_data_q <= '0;
			out_pos_q  <= '0;
			out_last_q <= 1'b1;
		end else if (rd_pend_s1) begin
			out_kind_q <= KIND_PAYLOAD;
			out_data_q <= rd_data_s1;
			out_pos_q  <= POS_W'(rd_pos_s1);
			out_last_q <= rd_last_s1;
		end
	end

	// counters hold while a beat waits since no byte is taken then
	always_comb begin
		m_tdata = '0;
		m_tdata[DATA_LSB +: 8]     = out_data_q;
		m_tdata[POS_LSB +: POS_W]  = out_pos_q;
		m_tdata[GOOD_LSB +: CNT_W] = good_q;
		m_tdata[BAD_LSB +: CNT_W]  = bad_q;
		m_tdata[SEEN_LSB +: CNT_W] = seen_q;
	end

	assign m_tuser = out_kind_q;
	assign m_tlast = out_last_q;

endmodule
`default_nettype wire

@@ design/hcfr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcfr_checker
// port-level checks of the frame receiver
// ----------------------------------------------------------------------------
module hcfr_checker
	import hcfr_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [TDATA_W-1:0]    m_tdata,
	input wire logic [0:0]            m_tuser,
	input wire logic                  m_tlast
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("result beat changed under stall");

	// error result is a single beat with cleared payload fields
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[0] == KIND_CKS_ERR)) |->
		(m_tlast && (m_tdata[DATA_LSB +: 8] == 8'd0) &&
		 (m_tdata[POS_LSB +: POS_W] == '0)))
		else $error("malformed checksum error beat");

	// no byte taken while a result waits
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("byte taken while result stalled");

	// byte count steps once per taken byte
	a_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(arst_n && s_tvalid && s_tready) |=>
		(m_tdata[SEEN_LSB +: CNT_W] == $past(m_tdata[SEEN_LSB +: CNT_W]) + CNT_W'(1)))
		else $error("byte count did not advance");

endmodule

bind header_checksum_frame_receiver hcfr_checker u_hcfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

@@ sim/hcfr_frame_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcfr_frame_checker
// watches the byte, result and register channels of the frame receiver, keeps
// its own frame sync and checksum state and compares every result beat
// ----------------------------------------------------------------------------
module hcfr_frame_checker
	import hcfr_pkg::*;
#(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	// [7:0] data_byte, [13:8] byte_position, [45:14] good_frames,
	// [77:46] bad_frames, [109:78] bytes_seen, [111:110] zero
	input  wire logic [TDATA_W-1:0]    m_tdata,
	input  wire logic [0:0]            m_tuser,   // [0] kind
	input  wire logic                  m_tlast,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         beats_waiting,
	output int                         beats_checked,
	output int                         frames_good,
	output int                         frames_bad
);

	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic             kind;
		logic [7:0]       data;
		logic [POS_W-1:0] pos;
		logic             last;
		logic [CNT_W-1:0] good;
		logic [CNT_W-1:0] bad;
		logic [CNT_W-1:0] seen;
	} frame_beat_t;

	frame_beat_t      expected_beats[$];
	logic [7:0]       sync_byte;
	logic [LEN_W-1:0] frame_len;
	logic             framing;
	int               fill;
	logic [7:0]       cks_sum;
	logic [7:0]       payload_copy[BUFFER_DEPTH];
	logic [CNT_W-1:0] seen_cnt;
	logic [CNT_W-1:0] good_cnt;
	logic [CNT_W-1:0] bad_cnt;

	// frame length clamped to what the store can hold
	function automatic int frame_span(logic [LEN_W-1:0] len);
		if (len < LENGTH_MIN) return LENGTH_MIN;
		if (len > BUFFER_DEPTH) return BUFFER_DEPTH;
		return len;
	endfunction

	function automatic frame_beat_t make_beat(logic kind, logic [7:0] data, int pos,
			logic last);
		frame_beat_t beat;
		beat.kind = kind;
		beat.data = data;
		beat.pos  = pos[POS_W-1:0];
		beat.last = last;
		beat.good = good_cnt;
		beat.bad  = bad_cnt;
		beat.seen = seen_cnt;
		return beat;
	endfunction

	task automatic report_fault(input string msg);
		if (fail_count < PRINT_LIMIT) $display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			report_fault($sformatf("beat %0d %s expected 0x%0h got 0x%0h",
				beats_checked, name, want, got));
	endtask

	// one link byte through hunt, store and checksum compare
	task automatic take_rx_byte(input logic [7:0] b);
		int n;
		int i;
		seen_cnt++;
		if (!framing) begin
			if (b == sync_byte) begin
				framing = 1'b1;
				fill    = 0;
				cks_sum = 8'd0;
			end
		end else if (fill + 1 < frame_span(frame_len)) begin
			payload_copy[fill] = b;
			cks_sum += b;
			fill++;
		end else begin
			n       = fill;
			framing = 1'b0;
			fill    = 0;
			if (cks_sum != b) begin
				bad_cnt++;
				expected_beats.push_back(make_beat(KIND_CKS_ERR, 8'd0, 0, 1'b1));
			end else begin
				good_cnt++;
				for (i = 0; i < n; i++)
					expected_beats.push_back(make_beat(KIND_PAYLOAD, payload_copy[i], i,
						i == n - 1));
			end
			cks_sum = 8'd0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_beat_t want;
		if (!arst_n) begin
			sync_byte = HEADER_RESET;
			frame_len = LENGTH_RESET;
			framing   = 1'b0;
			fill      = 0;
			cks_sum   = 8'd0;
			seen_cnt  = '0;
			good_cnt  = '0;
			bad_cnt   = '0;
			expected_beats.delete();
			fail_count    = 0;
			beats_waiting = 0;
			beats_checked = 0;
			frames_good   = 0;
			frames_bad    = 0;
		end else begin
			// a byte taken at the same edge as a write still sees the old settings
			if (s_tvalid === 1'b1 && s_tready === 1'b1) take_rx_byte(s_tdata);
			if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
				unique case (cfg_index)
					REG_HEADER_BYTE: sync_byte = cfg_data;
					REG_FRAME_LENGTH: frame_len = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				if (expected_beats.size() == 0) begin
					report_fault($sformatf("beat %0d arrived with nothing expected",
						beats_checked));
				end else begin
					want = expected_beats.pop_front();
					check_field("kind", want.kind, m_tuser[0]);
					check_field("data_byte", want.data, m_tdata[DATA_LSB +: 8]);
					check_field("byte_position", want.pos, m_tdata[POS_LSB +: POS_W]);
					check_field("last", want.last, m_tlast);
					check_field("good_frames", want.good, m_tdata[GOOD_LSB +: CNT_W]);
					check_field("bad_frames", want.bad, m_tdata[BAD_LSB +: CNT_W]);
					check_field("bytes_seen", want.seen, m_tdata[SEEN_LSB +: CNT_W]);
				end
				beats_checked++;
			end
			beats_waiting = expected_beats.size();
			frames_good   = good_cnt;
			frames_bad    = bad_cnt;
		end
	end

endmodule
`default_nettype wire

@@ sim/tb_header_checksum_frame_receiver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_header_checksum_frame_receiver
// drives link bytes and register writes into the frame receiver, stalls the
// result side at random; hcfr_frame_checker and the bound hcfr_checker check
// ----------------------------------------------------------------------------
module tb_header_checksum_frame_receiver;
	import hcfr_pkg::*;

	localparam int HALF_PERIOD   = 4;          // 8 ns clock
	localparam int RESET_CYCLES  = 12;
	localparam int ITEM_TARGET   = 460;        // link bytes, directed part included
	localparam int MAX_GAP       = 5;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 16;
	localparam int WATCHDOG_NS   = 2_000_000;  // far beyond the slowest legal run
	// register indexes with nothing behind them, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = 8'hFF;

	logic clk = 1'b0;
	logic arst_n;

	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;    // [7:0] rx_byte
	logic                  m_tvalid;
	logic                  m_tready;
	// [7:0] data_byte, [13:8] byte_position, [45:14] good_frames,
	// [77:46] bad_frames, [109:78] bytes_seen, [111:110] zero
	logic [TDATA_W-1:0]    m_tdata;
	logic [0:0]            m_tuser;    // [0] kind
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int beats_waiting;
	int beats_checked;
	int frames_good;
	int frames_bad;

	// stimulus bookkeeping
	bit               no_gaps;     // burst stretches with both sides idle-free
	int               bytes_sent;
	int               cfg_writes;
	logic [7:0]       cur_hdr;     // header the stimulus builds frames around
	logic [LEN_W-1:0] cur_len;

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	header_checksum_frame_receiver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hcfr_frame_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.beats_waiting (beats_waiting),
		.beats_checked (beats_checked),
		.frames_good   (frames_good),
		.frames_bad    (frames_bad)
	);

	// idle cycles before the next beat on either side
	function automatic int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// one link byte; tvalid stays high afterwards so that back-to-back bytes
	// need no second assignment in the same step, the drain lowers it
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = draw_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (s_tready !== 1'b1);
		bytes_sent++;
	endtask

	// stop the byte stream and wait until every predicted beat has come out;
	// the count is read at the falling edge, clear of the checker's update
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (beats_waiting != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only ever with the byte stream stopped and all results drained
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		cfg_writes++;
		if (idx == REG_HEADER_BYTE) cur_hdr = data;
		else if (idx == REG_FRAME_LENGTH) cur_len = data[LEN_W-1:0];
	endtask

	// header, random payload, then the checksum, deliberately wrong on request
	task automatic send_frame(input int n_payload, input bit corrupt);
		logic [7:0] sum;
		logic [7:0] b;
		send_byte(cur_hdr);
		sum = 8'd0;
		repeat (n_payload) begin
			b = 8'($urandom_range(0, 255));
			sum += b;
			send_byte(b);
		end
		b = 8'($urandom_range(1, 255));
		send_byte(corrupt ? sum + b : sum);
	endtask

	// line noise that never looks like the header
	task automatic send_noise(input int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			if (b == cur_hdr) b = ~b;
			send_byte(b);
		end
	endtask

	// result side: a fresh stall before each beat
	initial begin : result_sink
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
		end
	end

	initial begin : stimulus
		int               phase;
		int               span;
		int               frames;
		int               style;
		int               pick;
		logic [7:0]       len_cfg;
		logic [7:0]       hdr_cfg;
		logic [CFG_IDX_W-1:0] spare_idx;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		no_gaps    = 1'b0;
		bytes_sent = 0;
		cfg_writes = 0;
		cur_hdr    = HEADER_RESET;
		cur_len    = LENGTH_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// shortest frame, one payload byte; all-zero good frame, all-ones bad
		write_reg(REG_HEADER_BYTE, 8'hFF);
		write_reg(REG_FRAME_LENGTH, 8'd2);
		send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00);
		send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFE);
		// length below the minimum behaves as the minimum
		write_reg(REG_FRAME_LENGTH, 8'd0);
		send_byte(8'hFF); send_byte(8'h80); send_byte(8'h80);
		// zero header, and the header value showing up again inside the payload
		write_reg(REG_HEADER_BYTE, 8'h00);
		write_reg(REG_FRAME_LENGTH, 8'd3);
		send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF); send_byte(8'hFF);
		// length shrunk mid-frame: the next byte is taken as the checksum
		write_reg(REG_FRAME_LENGTH, 8'd6);
		send_byte(8'h00); send_byte(8'h01); send_byte(8'h02); send_byte(8'h03);
		write_reg(REG_FRAME_LENGTH, 8'd3);
		send_byte(8'h06);
		// length grown mid-frame: the frame keeps storing
		write_reg(REG_FRAME_LENGTH, 8'd2);
		send_byte(8'h00); send_byte(8'h05);
		write_reg(REG_FRAME_LENGTH, 8'd3);
		send_byte(8'h0A); send_byte(8'h0F);
		// header changed mid-frame: the new value is plain payload until the
		// frame closes, then it is what the hunt looks for
		send_byte(8'h00); send_byte(8'h11);
		write_reg(REG_HEADER_BYTE, 8'h22);
		send_byte(8'h22); send_byte(8'h33);
		// unmapped index with every index bit set
		write_reg(REG_SPARE_TOP, 8'hA5);

		// ---- random part ----
		// each phase: new settings, then mostly well-formed frames with random
		// payload, some corrupt checksums, noise, raw bytes and cut-off frames;
		// a cut-off frame at the end of a phase puts the next writes mid-frame
		phase = 0;
		while (bytes_sent < ITEM_TARGET) begin
			unique case (phase)
				0: len_cfg = 8'd64;    // full store depth
				1: len_cfg = 8'd127;   // above the store, clamps to it
				2: len_cfg = 8'd1;     // below the minimum
				3: len_cfg = 8'h83;    // bit 7 falls outside the register
				default: begin
					pick = $urandom_range(0, 19);
					if (pick == 0) len_cfg = 8'd28;
					else if (pick == 1) len_cfg = 8'd0;
					else if (pick == 2) len_cfg = 8'($urandom_range(29, 127));
					else len_cfg = 8'($urandom_range(2, 9));
					len_cfg[7] = ($urandom_range(0, 7) == 0);
				end
			endcase
			pick = $urandom_range(0, 9);
			if (pick == 0) hdr_cfg = 8'h00;
			else if (pick == 1) hdr_cfg = 8'hFF;
			else hdr_cfg = 8'($urandom_range(0, 255));

			if ($urandom_range(0, 1) == 1) begin
				write_reg(REG_FRAME_LENGTH, len_cfg);
				write_reg(REG_HEADER_BYTE, hdr_cfg);
			end else begin
				write_reg(REG_HEADER_BYTE, hdr_cfg);
				write_reg(REG_FRAME_LENGTH, len_cfg);
			end
			if ($urandom_range(0, 7) == 0) begin
				spare_idx = CFG_IDX_W'($urandom_range(REG_SPARE_LOW, REG_SPARE_TOP));
				write_reg(spare_idx, CFG_DATA_W'($urandom_range(0, 255)));
			end

			span = (cur_len < LENGTH_MIN) ? LENGTH_MIN :
				(cur_len > BUFFER_DEPTH_DEF) ? BUFFER_DEPTH_DEF : cur_len;
			frames  = (span > 16) ? 1 : $urandom_range(2, 6);
			no_gaps = ($urandom_range(0, 3) == 0);

			repeat (frames) begin
				style = $urandom_range(0, 9);
				if (style == 0) begin
					// raw bytes, the header may turn up anywhere
					repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
				end else if (style == 1) begin
					// frame cut off before its checksum
					send_byte(cur_hdr);
					repeat ($urandom_range(0, span - 2))
						send_byte(8'($urandom_range(0, 255)));
				end else begin
					send_noise($urandom_range(0, 2));
					send_frame(span - 1, $urandom_range(0, 3) == 0);
				end
			end
			phase++;
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d link bytes in %0d setting phases, %0d register writes",
			bytes_sent, phase, cfg_writes);
		$display("compared %0d result beats from %0d good frames and %0d checksum errors",
			beats_checked, frames_good, frames_bad);
		if (fail_count == 0 && beats_waiting == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin : watchdog
		#(WATCHDOG_NS);
		$display("timeout with %0d result beats outstanding", beats_waiting);
		$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
